>>> hdl/dcps_pkg.sv
package dcps_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_BODIES = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int MUL_W      = 36;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIV_W      = 48;

   localparam logic [16:0] BOUNCE_ONE      = 17'd65536;
   localparam logic [30:0] TIME_STEP_RESET = 31'd1092;

   localparam logic [7:0] REG_TIME_STEP  = 8'd0;
   localparam logic [7:0] REG_BODY_COUNT = 8'd1;

   localparam logic [1:0] CMD_LOAD      = 2'd0;
   localparam logic [1:0] CMD_INTEGRATE = 2'd1;
   localparam logic [1:0] CMD_SOLVE     = 2'd2;
   localparam logic [1:0] CMD_READ      = 2'd3;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] angle;
      logic signed [31:0] spin;
      logic        [30:0] radius;
      logic        [30:0] mass;
      logic        [16:0] bounce;
   } body_type;

   // base + delta (or base - delta), clipped to the signed 32-bit range
   function automatic logic signed [31:0] add_sat(input logic signed [31:0] base,
                                                  input logic signed [PROD_W-1:0] delta,
                                                  input logic neg);
      logic signed [PROD_W:0] sum;
      sum = neg ? ((PROD_W+1)'(base) - (PROD_W+1)'(delta))
                : ((PROD_W+1)'(base) + (PROD_W+1)'(delta));
      if (!sum[PROD_W] && (|sum[PROD_W-1:31])) begin
         return 32'sh7FFF_FFFF;
      end else if (sum[PROD_W] && !(&sum[PROD_W-1:31])) begin
         return 32'sh8000_0000;
      end
      return sum[31:0];
   endfunction

endpackage

>>> hdl/disk_collision_physics_step.sv
// Load: one body per request. Integrate: each active body in turn.
// Read: one transfer per body; an rsp stall holds the walk.
// Solve: the time per pair is set by the overlap test and, for an overlapping pair,
// by the bit-serial square root (32 steps) and the shared radix-2 divider
// (48 steps per quotient, two without impulse and four with impulse).
// Reset (synchronous, active high) clears control, time_step to 1092, body_count to 0.
module disk_collision_physics_step
   import dcps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // slave side
   input  logic         req_tvalid,
   output logic         req_tready,
   // index, pos_x, pos_y, vel_x, vel_y, angle, ang_vel, radius, mass, restitution
   input  logic [279:0] req_tdata,
   // cmd
   input  logic [1:0]   req_tuser,
   // master side
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // body_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y, out_angle, out_ang_vel
   output logic [199:0] rsp_tdata,
   output logic         rsp_tlast,
   // configuration writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);

   typedef enum logic [41:0] {
      ST_IDLE    = 42'd1 << 0,
      ST_INT_RD  = 42'd1 << 1,
      ST_INT_CAP = 42'd1 << 2,
      ST_INT_MX  = 42'd1 << 3,
      ST_INT_MY  = 42'd1 << 4,
      ST_INT_MA  = 42'd1 << 5,
      ST_INT_AN  = 42'd1 << 6,
      ST_INT_WR  = 42'd1 << 7,
      ST_OUT_RD  = 42'd1 << 8,
      ST_OUT_CAP = 42'd1 << 9,
      ST_OUT_HLD = 42'd1 << 10,
      ST_P_RDA   = 42'd1 << 11,
      ST_P_RDB   = 42'd1 << 12,
      ST_P_CAPB  = 42'd1 << 13,
      ST_P_SQX   = 42'd1 << 14,
      ST_P_SQY   = 42'd1 << 15,
      ST_P_SS    = 42'd1 << 16,
      ST_P_CMP   = 42'd1 << 17,
      ST_P_SQRT  = 42'd1 << 18,
      ST_P_DEPTH = 42'd1 << 19,
      ST_P_DIVX  = 42'd1 << 20,
      ST_P_NX    = 42'd1 << 21,
      ST_P_DIVY  = 42'd1 << 22,
      ST_P_NY    = 42'd1 << 23,
      ST_P_OX    = 42'd1 << 24,
      ST_P_OY    = 42'd1 << 25,
      ST_P_VN1   = 42'd1 << 26,
      ST_P_VN2   = 42'd1 << 27,
      ST_P_CHK   = 42'd1 << 28,
      ST_P_G     = 42'd1 << 29,
      ST_P_DIVA  = 42'd1 << 30,
      ST_P_QA    = 42'd1 << 31,
      ST_P_DIVB  = 42'd1 << 32,
      ST_P_QB    = 42'd1 << 33,
      ST_P_GA    = 42'd1 << 34,
      ST_P_GB    = 42'd1 << 35,
      ST_P_VAX   = 42'd1 << 36,
      ST_P_VAY   = 42'd1 << 37,
      ST_P_VBX   = 42'd1 << 38,
      ST_P_VBY   = 42'd1 << 39,
      ST_P_WRA   = 42'd1 << 40,
      ST_P_WRB   = 42'd1 << 41
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [30:0] time_step_ff;
   logic [6:0]  body_count_ff;

   // body store: one write port, one registered read port
   body_type mem [MAX_BODIES];
   body_type rd_q_ff;
   logic     wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   body_type wr_data;

   // loop indices and working copies of the two bodies
   logic [CNT_W-1:0] i_ff, j_ff;
   logic [CNT_W-1:0] n_act;
   body_type a_ff, b_ff;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   logic signed [PROD_W-1:0] prod_shr;

   // square root unit
   logic [63:0] sq_val_ff;
   logic [33:0] sq_rem_ff;
   logic [31:0] sq_root_ff;
   logic [35:0] sq_rem_sh, sq_trial;
   logic        sq_ge;

   // divider unit
   logic [DIV_W-1:0] div_num_ff, div_quo_ff;
   logic [31:0]      div_den_ff, div_rem_ff;
   logic [32:0]      div_rem_sh;
   logic             div_ge;

   logic [5:0] cnt_ff;

   // pair results
   logic [65:0]        d2_ff;
   logic [30:0]        depth_ff;
   logic signed [17:0] nx_ff, ny_ff;
   logic signed [35:0] ox_ff, vn_ff;
   logic [34:0]        g_ff, ga_ff, gb_ff;
   logic [16:0]        qa_ff, qb_ff;

   // output register
   logic         rsp_valid_ff;
   logic [199:0] rsp_data_ff;
   logic         rsp_last_ff;

   // input fields
   logic [1:0]  req_cmd;
   logic [5:0]  req_index;
   logic [16:0] req_restitution;
   logic        req_xfer;
   body_type    load_body;

   // pair geometry
   logic signed [32:0] dx, dy, dvx, dvy;
   logic [32:0] ax, ay;
   logic [31:0] s_sum, msum;
   logic [16:0] e_min;
   logic        pair_more_j, pair_more_i;

   assign req_cmd         = req_tuser;
   assign req_index       = req_tdata[5:0];
   assign req_restitution = req_tdata[276:260];
   assign req_tready      = (state_ff == ST_IDLE);
   assign req_xfer        = req_tvalid && req_tready;
   assign csr_ready       = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      load_body.pos_x  = req_tdata[37:6];
      load_body.pos_y  = req_tdata[69:38];
      load_body.vel_x  = req_tdata[101:70];
      load_body.vel_y  = req_tdata[133:102];
      load_body.angle  = req_tdata[165:134];
      load_body.spin   = req_tdata[197:166];
      load_body.radius = req_tdata[228:198];
      load_body.mass   = req_tdata[259:229];
      // clamp restitution above 1.0
      load_body.bounce = (req_restitution > BOUNCE_ONE) ? BOUNCE_ONE : req_restitution;
   end

   assign n_act = (body_count_ff > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : body_count_ff;

   always_comb begin
      dx    = {a_ff.pos_x[31], a_ff.pos_x} - {b_ff.pos_x[31], b_ff.pos_x};
      dy    = {a_ff.pos_y[31], a_ff.pos_y} - {b_ff.pos_y[31], b_ff.pos_y};
      dvx   = {a_ff.vel_x[31], a_ff.vel_x} - {b_ff.vel_x[31], b_ff.vel_x};
      dvy   = {a_ff.vel_y[31], a_ff.vel_y} - {b_ff.vel_y[31], b_ff.vel_y};
      ax    = dx[32] ? 33'(-dx) : 33'(dx);
      ay    = dy[32] ? 33'(-dy) : 33'(dy);
      s_sum = {1'b0, a_ff.radius} + {1'b0, b_ff.radius};
      msum  = {1'b0, a_ff.mass} + {1'b0, b_ff.mass};
      e_min = (a_ff.bounce < b_ff.bounce) ? a_ff.bounce : b_ff.bounce;
   end

   assign pair_more_j = (j_ff + CNT_W'(1)) < n_act;
   assign pair_more_i = (i_ff + CNT_W'(2)) < n_act;

   // square root step: two radicand bits in, one root bit out
   always_comb begin
      sq_rem_sh = {sq_rem_ff, sq_val_ff[63:62]};
      sq_trial  = {2'b00, sq_root_ff, 2'b01};
      sq_ge     = (sq_rem_sh >= sq_trial);
   end

   // restoring divide step: one quotient bit
   always_comb begin
      div_rem_sh = {div_rem_ff, div_num_ff[DIV_W-1]};
      div_ge     = (div_rem_sh >= {1'b0, div_den_ff});
   end

   assign prod_shr = prod_ff >>> FRAC_BITS;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_INT_MX: begin
            mul_a = MUL_W'(a_ff.vel_x);
            mul_b = {5'b0, time_step_ff};
         end
         ST_INT_MY: begin
            mul_a = MUL_W'(a_ff.vel_y);
            mul_b = {5'b0, time_step_ff};
         end
         ST_INT_MA: begin
            mul_a = MUL_W'(a_ff.spin);
            mul_b = {5'b0, time_step_ff};
         end
         ST_P_SQX: begin
            mul_a = {3'b0, ax};
            mul_b = {3'b0, ax};
         end
         ST_P_SQY: begin
            mul_a = {3'b0, ay};
            mul_b = {3'b0, ay};
         end
         ST_P_SS: begin
            mul_a = {4'b0, s_sum};
            mul_b = {4'b0, s_sum};
         end
         ST_P_NY: begin
            mul_a = MUL_W'(nx_ff);
            mul_b = {5'b0, depth_ff};
         end
         ST_P_OX: begin
            mul_a = MUL_W'(ny_ff);
            mul_b = {5'b0, depth_ff};
         end
         ST_P_OY: begin
            mul_a = MUL_W'(nx_ff);
            mul_b = MUL_W'(dvx);
         end
         ST_P_VN1: begin
            mul_a = MUL_W'(ny_ff);
            mul_b = MUL_W'(dvy);
         end
         ST_P_CHK: begin
            mul_a = {18'b0, 18'(BOUNCE_ONE) + 18'(e_min)};
            mul_b = -vn_ff;
         end
         ST_P_QB: begin
            mul_a = {1'b0, g_ff};
            mul_b = {19'b0, qa_ff};
         end
         ST_P_GA: begin
            mul_a = {1'b0, g_ff};
            mul_b = {19'b0, qb_ff};
         end
         ST_P_GB: begin
            mul_a = {1'b0, ga_ff};
            mul_b = MUL_W'(nx_ff);
         end
         ST_P_VAX: begin
            mul_a = {1'b0, ga_ff};
            mul_b = MUL_W'(ny_ff);
         end
         ST_P_VAY: begin
            mul_a = {1'b0, gb_ff};
            mul_b = MUL_W'(nx_ff);
         end
         ST_P_VBX: begin
            mul_a = {1'b0, gb_ff};
            mul_b = MUL_W'(ny_ff);
         end
         default: begin
         end
      endcase
   end

   // body store port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff[IDX_W-1:0];
      wr_data = a_ff;
      rd_addr = i_ff[IDX_W-1:0];
      unique case (state_ff) inside
         ST_IDLE: begin
            // a 6-bit index always falls inside the store
            wr_en   = req_xfer && (req_cmd == CMD_LOAD);
            wr_addr = req_index;
            wr_data = load_body;
         end
         ST_INT_WR, ST_P_WRA: begin
            wr_en = 1'b1;
         end
         ST_P_WRB: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = b_ff;
         end
         ST_P_RDB: begin
            rd_addr = j_ff[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_cmd)
                  CMD_INTEGRATE: if (n_act != '0) state_in = ST_INT_RD;
                  CMD_SOLVE:     if (n_act > CNT_W'(1)) state_in = ST_P_RDA;
                  CMD_READ:      if (n_act != '0) state_in = ST_OUT_RD;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_INT_RD:  state_in = ST_INT_CAP;
         ST_INT_CAP: state_in = ST_INT_MX;
         ST_INT_MX:  state_in = ST_INT_MY;
         ST_INT_MY:  state_in = ST_INT_MA;
         ST_INT_MA:  state_in = ST_INT_AN;
         ST_INT_AN:  state_in = ST_INT_WR;
         ST_INT_WR:  state_in = ((i_ff + CNT_W'(1)) < n_act) ? ST_INT_RD : ST_IDLE;
         ST_OUT_RD:  state_in = ST_OUT_CAP;
         ST_OUT_CAP: state_in = ST_OUT_HLD;
         ST_OUT_HLD: begin
            if (rsp_tready) begin
               state_in = ((i_ff + CNT_W'(1)) < n_act) ? ST_OUT_RD : ST_IDLE;
            end
         end
         ST_P_RDA:  state_in = ST_P_RDB;
         ST_P_RDB:  state_in = ST_P_CAPB;
         ST_P_CAPB: state_in = ST_P_SQX;
         ST_P_SQX:  state_in = ST_P_SQY;
         ST_P_SQY:  state_in = ST_P_SS;
         ST_P_SS:   state_in = ST_P_CMP;
         ST_P_CMP: begin
            if ((d2_ff >= prod_ff[65:0]) || (d2_ff == '0)) begin
               state_in = (pair_more_j || pair_more_i) ? ST_P_RDA : ST_IDLE;
            end else begin
               state_in = ST_P_SQRT;
            end
         end
         ST_P_SQRT:  if (cnt_ff == 6'd31) state_in = ST_P_DEPTH;
         ST_P_DEPTH: state_in = ST_P_DIVX;
         ST_P_DIVX:  if (cnt_ff == 6'(DIV_W - 1)) state_in = ST_P_NX;
         ST_P_NX:    state_in = ST_P_DIVY;
         ST_P_DIVY:  if (cnt_ff == 6'(DIV_W - 1)) state_in = ST_P_NY;
         ST_P_NY:    state_in = ST_P_OX;
         ST_P_OX:    state_in = ST_P_OY;
         ST_P_OY:    state_in = ST_P_VN1;
         ST_P_VN1:   state_in = ST_P_VN2;
         ST_P_VN2:   state_in = ST_P_CHK;
         ST_P_CHK: begin
            // skip the impulse for a separating pair or zero total mass
            state_in = (!vn_ff[35] || (msum == '0)) ? ST_P_WRA : ST_P_G;
         end
         ST_P_G:    state_in = ST_P_DIVA;
         ST_P_DIVA: if (cnt_ff == 6'(DIV_W - 1)) state_in = ST_P_QA;
         ST_P_QA:   state_in = ST_P_DIVB;
         ST_P_DIVB: if (cnt_ff == 6'(DIV_W - 1)) state_in = ST_P_QB;
         ST_P_QB:   state_in = ST_P_GA;
         ST_P_GA:   state_in = ST_P_GB;
         ST_P_GB:   state_in = ST_P_VAX;
         ST_P_VAX:  state_in = ST_P_VAY;
         ST_P_VAY:  state_in = ST_P_VBX;
         ST_P_VBX:  state_in = ST_P_VBY;
         ST_P_VBY:  state_in = ST_P_WRA;
         ST_P_WRA:  state_in = ST_P_WRB;
         ST_P_WRB:  state_in = (pair_more_j || pair_more_i) ? ST_P_RDA : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_step_ff  <= TIME_STEP_RESET;
         body_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_TIME_STEP:  time_step_ff  <= csr_data[30:0];
               REG_BODY_COUNT: body_count_ff <= csr_data[6:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_OUT_CAP) begin
            rsp_valid_ff <= 1'b1;
         end else if ((state_ff == ST_OUT_HLD) && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      cnt_ff  <= cnt_ff + 6'd1;

      // advance the pair walk
      if (((state_ff == ST_P_CMP) && (state_in != ST_P_SQRT)) || (state_ff == ST_P_WRB)) begin
         if (pair_more_j) begin
            j_ff <= j_ff + CNT_W'(1);
         end else begin
            i_ff <= i_ff + CNT_W'(1);
            j_ff <= i_ff + CNT_W'(2);
         end
      end

      case (state_ff) inside
         ST_IDLE: begin
            i_ff <= '0;
            j_ff <= CNT_W'(1);
         end
         ST_INT_CAP: a_ff <= rd_q_ff;
         ST_INT_MY:  a_ff.pos_x <= add_sat(a_ff.pos_x, prod_shr, 1'b0);
         ST_INT_MA:  a_ff.pos_y <= add_sat(a_ff.pos_y, prod_shr, 1'b0);
         ST_INT_AN:  a_ff.angle <= add_sat(a_ff.angle, prod_shr, 1'b0);
         ST_INT_WR:  i_ff <= i_ff + CNT_W'(1);
         ST_OUT_CAP: begin
            rsp_data_ff <= {2'b00, rd_q_ff.spin, rd_q_ff.angle, rd_q_ff.vel_y,
                            rd_q_ff.vel_x, rd_q_ff.pos_y, rd_q_ff.pos_x,
                            i_ff[IDX_W-1:0]};
            rsp_last_ff <= ((i_ff + CNT_W'(1)) == n_act);
         end
         ST_OUT_HLD: if (rsp_tready) i_ff <= i_ff + CNT_W'(1);
         ST_P_RDB:   a_ff <= rd_q_ff;
         ST_P_CAPB:  b_ff <= rd_q_ff;
         ST_P_SQY:   acc_ff <= prod_ff;
         ST_P_SS:    d2_ff <= 66'(acc_ff + prod_ff);
         ST_P_CMP: begin
            sq_val_ff  <= d2_ff[63:0];
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
            cnt_ff     <= '0;
         end
         ST_P_SQRT: begin
            sq_val_ff  <= {sq_val_ff[61:0], 2'b00};
            sq_rem_ff  <= 34'(sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh);
            sq_root_ff <= {sq_root_ff[30:0], sq_ge};
         end
         ST_P_DEPTH: begin
            depth_ff   <= 31'((s_sum - sq_root_ff) >> 1);
            div_num_ff <= {ax[31:0], 16'b0};
            div_den_ff <= sq_root_ff;
            div_rem_ff <= '0;
            div_quo_ff <= '0;
            cnt_ff     <= '0;
         end
         ST_P_DIVX, ST_P_DIVY, ST_P_DIVA, ST_P_DIVB: begin
            div_num_ff <= {div_num_ff[DIV_W-2:0], 1'b0};
            div_rem_ff <= 32'(div_ge ? (div_rem_sh - {1'b0, div_den_ff}) : div_rem_sh);
            div_quo_ff <= {div_quo_ff[DIV_W-2:0], div_ge};
         end
         ST_P_NX: begin
            nx_ff      <= dx[32] ? -signed'(div_quo_ff[17:0]) : signed'(div_quo_ff[17:0]);
            div_num_ff <= {ay[31:0], 16'b0};
            div_rem_ff <= '0;
            div_quo_ff <= '0;
            cnt_ff     <= '0;
         end
         ST_P_NY: begin
            ny_ff <= dy[32] ? -signed'(div_quo_ff[17:0]) : signed'(div_quo_ff[17:0]);
         end
         ST_P_OX: ox_ff <= prod_shr[35:0];
         ST_P_OY: begin
            // push the pair apart by half the overlap
            a_ff.pos_x <= add_sat(a_ff.pos_x, PROD_W'(ox_ff), 1'b0);
            b_ff.pos_x <= add_sat(b_ff.pos_x, PROD_W'(ox_ff), 1'b1);
            a_ff.pos_y <= add_sat(a_ff.pos_y, prod_shr, 1'b0);
            b_ff.pos_y <= add_sat(b_ff.pos_y, prod_shr, 1'b1);
         end
         ST_P_VN1: acc_ff <= prod_ff;
         ST_P_VN2: vn_ff  <= 36'((acc_ff + prod_ff) >>> FRAC_BITS);
         ST_P_G: begin
            g_ff       <= prod_ff[50:16];
            div_num_ff <= {1'b0, b_ff.mass, 16'b0};
            div_den_ff <= msum;
            div_rem_ff <= '0;
            div_quo_ff <= '0;
            cnt_ff     <= '0;
         end
         ST_P_QA: begin
            qa_ff      <= div_quo_ff[16:0];
            div_num_ff <= {1'b0, a_ff.mass, 16'b0};
            div_rem_ff <= '0;
            div_quo_ff <= '0;
            cnt_ff     <= '0;
         end
         ST_P_QB:  qb_ff <= div_quo_ff[16:0];
         ST_P_GA:  ga_ff <= prod_ff[50:16];
         ST_P_GB:  gb_ff <= prod_ff[50:16];
         ST_P_VAX: a_ff.vel_x <= add_sat(a_ff.vel_x, prod_shr, 1'b0);
         ST_P_VAY: a_ff.vel_y <= add_sat(a_ff.vel_y, prod_shr, 1'b0);
         ST_P_VBX: b_ff.vel_x <= add_sat(b_ff.vel_x, prod_shr, 1'b1);
         ST_P_VBY: b_ff.vel_y <= add_sat(b_ff.vel_y, prod_shr, 1'b1);
         default: begin
         end
      endcase
   end

endmodule
